// ===== rtl/nsfs_pkg.sv =====
// Shared types and constants for the NMEA sentence field splitter.
package nsfs_pkg;

    localparam int unsigned TagW          = 40;
    localparam int unsigned ByteW         = 8;
    localparam int unsigned IdxW          = 4;
    localparam int unsigned PosW          = 4;

    localparam logic [TagW-1:0]  TAG_RESET = 40'h4750524D43;
    localparam logic [ByteW-1:0] CH_START  = 8'h24;
    localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
    localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
    localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;

    localparam int unsigned DEF_MAX_FIELDS      = 13;
    localparam int unsigned DEF_MAX_FIELD_CHARS = 16;
    localparam int unsigned DEF_QUEUE_DEPTH     = 4;

    typedef struct packed {
        logic             sentence_end;
        logic [ByteW-1:0] char_value;
        logic [PosW-1:0]  char_pos;
        logic [IdxW-1:0]  field_index;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/nmea_sentence_field_splitter_core.sv =====
// Top level of the NMEA sentence field splitter.
//
// Input stream: one received character per beat in s_axis_tdata.
// Output stream: one beat per field character of a sentence whose tag
// matches the configured tag; m_axis_tdata carries field number, position
// in field and character, m_axis_tlast marks the carriage-return end beat.
// Config: i_cfg_wr_en writes the 40-bit sentence tag (first character in
// the top byte); write only while no output beat is pending.
// Path: a result beat is written into the queue after classification, then moved
// into the output register before it shows on m_axis.
// Throughput: one input beat per cycle, set by the front end state update for each
// accepted beat; the queue of QUEUE_DEPTH entries plus the output register
// absorb receiver stalls, and s_axis_tready drops only when the queue fills.
// Reset: tag returns to GPRMC, no sentence open, queue and output emptied.
module nmea_sentence_field_splitter_core
    import nsfs_pkg::*;
#(
    parameter int unsigned MAX_FIELDS      = DEF_MAX_FIELDS,
    parameter int unsigned MAX_FIELD_CHARS = DEF_MAX_FIELD_CHARS,
    parameter int unsigned QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TagW-1:0]  i_cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [3:0] field_index, [7:4] char_pos, [15:8] char_value
    output logic             m_axis_tlast
);

    logic          in_accept;
    logic          push;
    logic          pop;
    t_item         front_item;
    t_item         queue_item;
    t_item         out_item;
    t_queue_status queue_status;

    assign s_axis_tready = !queue_status.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    nsfs_front #(
        .MAX_FIELDS      (MAX_FIELDS),
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_byte        (s_axis_tdata),
        .o_push        (push),
        .o_item        (front_item)
    );

    nsfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (queue_status)
    );

    nsfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (queue_item),
        .i_status (queue_status),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_item   (out_item)
    );

    assign m_axis_tdata = {out_item.char_value, out_item.char_pos, out_item.field_index};
    assign m_axis_tlast = out_item.sentence_end;

endmodule

// ===== rtl/nsfs_front.sv =====
// Front end: accepts received bytes, tracks sentence state, emits field characters.
module nsfs_front
    import nsfs_pkg::*;
#(
    parameter int unsigned MAX_FIELDS      = DEF_MAX_FIELDS,
    parameter int unsigned MAX_FIELD_CHARS = DEF_MAX_FIELD_CHARS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TagW-1:0]   i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [ByteW-1:0]  i_byte,
    output logic              o_push,
    output t_item             o_item
);

    localparam logic [2:0] PH_FIELDS = 3'd5;
    localparam logic [2:0] PH_PAST   = 3'd6;
    localparam logic [2:0] PH_FULL   = 3'd7;

    logic [TagW-1:0]  r_tag;
    logic [2:0]       r_tag_pos, n_tag_pos;
    logic             r_tag_ok, n_tag_ok;
    logic             r_in_sent, n_in_sent;
    logic [IdxW-1:0]  r_field_cnt, n_field_cnt;
    logic [PosW-1:0]  r_pos, n_pos;
    logic [ByteW-1:0] tag_char;
    logic             is_sep;

    always_comb begin
        case (r_tag_pos)
            3'd0:    tag_char = r_tag[39:32];
            3'd1:    tag_char = r_tag[31:24];
            3'd2:    tag_char = r_tag[23:16];
            3'd3:    tag_char = r_tag[15:8];
            default: tag_char = r_tag[7:0];
        endcase
    end

    assign is_sep = (i_byte == CH_COMMA) || (i_byte == CH_STAR);

    always_comb begin
        n_tag_pos   = r_tag_pos;
        n_tag_ok    = r_tag_ok;
        n_in_sent   = r_in_sent;
        n_field_cnt = r_field_cnt;
        n_pos       = r_pos;
        o_push      = 1'b0;
        o_item.field_index  = r_field_cnt;
        o_item.char_pos     = r_pos;
        o_item.char_value   = i_byte;
        o_item.sentence_end = 1'b0;
        if (i_accept) begin
            if (i_byte == CH_START) begin
                n_in_sent   = 1'b1;
                n_tag_pos   = 3'd0;
                n_tag_ok    = 1'b1;
                n_field_cnt = '0;
                n_pos       = '0;
            end else if (r_in_sent) begin
                if (r_tag_pos < PH_FIELDS) begin
                    if (i_byte == CH_CR) begin
                        n_in_sent = 1'b0;
                    end else begin
                        if (i_byte != tag_char) begin
                            n_tag_ok = 1'b0;
                        end
                        n_tag_pos = r_tag_pos + 3'd1;
                    end
                end else if (i_byte == CH_CR) begin
                    n_in_sent = 1'b0;
                    o_push    = r_tag_ok;
                    o_item.char_pos     = '0;
                    o_item.sentence_end = 1'b1;
                end else if (r_tag_ok && (r_tag_pos != PH_PAST)) begin
                    if (is_sep) begin
                        if (r_field_cnt < IdxW'(MAX_FIELDS)) begin
                            n_field_cnt = r_field_cnt + 1'b1;
                            n_pos       = '0;
                            n_tag_pos   = PH_FIELDS;
                        end else begin
                            n_tag_pos = PH_PAST;
                        end
                    end else if ((r_field_cnt != '0) && (r_tag_pos != PH_FULL)) begin
                        o_push = 1'b1;
                        if (({1'b0, r_pos} + 5'd1) < 5'(MAX_FIELD_CHARS)) begin
                            n_pos = r_pos + 1'b1;
                        end else begin
                            n_tag_pos = PH_FULL;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= TAG_RESET;
            r_tag_pos   <= '0;
            r_tag_ok    <= 1'b0;
            r_in_sent   <= 1'b0;
            r_field_cnt <= '0;
            r_pos       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tag <= i_cfg_wr_data;
            end
            r_tag_pos   <= n_tag_pos;
            r_tag_ok    <= n_tag_ok;
            r_in_sent   <= n_in_sent;
            r_field_cnt <= n_field_cnt;
            r_pos       <= n_pos;
        end
    end

endmodule

// ===== rtl/nsfs_queue.sv =====
// Short result queue between the front end and the output stage.
module nsfs_queue
    import nsfs_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_status.full  = (r_count == CntW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/nsfs_back.sv =====
// Output stage: drains the queue into a registered stream beat.
module nsfs_back
    import nsfs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_item         i_item,
    input  t_queue_status i_status,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output t_item         o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_pop   = !i_status.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== tb/nmea_split_checker.sv =====
`timescale 1ns / 1ps
// Checker for the NMEA field splitter: predicts field beats from input beats and compares.
module nmea_split_checker
    import nsfs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [TagW-1:0] i_cfg_wr_data,
    input  logic            s_axis_tvalid,
    input  logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  logic [15:0]     m_axis_tdata,
    input  logic            m_axis_tlast,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_result_count
);

    localparam logic [2:0] PH_FIELDS = 3'd5;
    localparam logic [2:0] PH_PAST   = 3'd6;
    localparam logic [2:0] PH_FULL   = 3'd7;

    logic [TagW-1:0] tag_r;
    logic [2:0]      tag_pos;
    logic            tag_ok;
    logic            in_sentence;
    logic [IdxW-1:0] field_count;
    logic [PosW-1:0] pos_in_field;
    t_item           field_char_q[$];
    int              fails   = 0;
    int              results = 0;

    task automatic split_char(input logic [7:0] b);
        t_item it;
        it = '0;
        if (b == CH_START) begin
            in_sentence  = 1'b1;
            tag_pos      = '0;
            tag_ok       = 1'b1;
            field_count  = '0;
            pos_in_field = '0;
            return;
        end
        if (!in_sentence) return;
        if (tag_pos < PH_FIELDS) begin
            if (b == CH_CR) begin
                in_sentence = 1'b0;
                return;
            end
            if (b != tag_r[8 * (4 - int'(tag_pos)) +: 8]) tag_ok = 1'b0;
            tag_pos = tag_pos + 3'd1;
            return;
        end
        if (b == CH_CR) begin
            in_sentence = 1'b0;
            if (tag_ok) begin
                it.field_index  = field_count;
                it.char_pos     = '0;
                it.char_value   = CH_CR;
                it.sentence_end = 1'b1;
                field_char_q.push_back(it);
            end
            return;
        end
        if (!tag_ok || tag_pos == PH_PAST) return;
        if (b == CH_COMMA || b == CH_STAR) begin
            if (int'(field_count) < DEF_MAX_FIELDS) begin
                field_count  = field_count + 4'd1;
                pos_in_field = '0;
                tag_pos      = PH_FIELDS;
            end else begin
                tag_pos = PH_PAST;
            end
            return;
        end
        if (field_count == 0 || tag_pos == PH_FULL) return;
        it.field_index  = field_count;
        it.char_pos     = pos_in_field;
        it.char_value   = b;
        it.sentence_end = 1'b0;
        field_char_q.push_back(it);
        if (int'(pos_in_field) + 1 < DEF_MAX_FIELD_CHARS) begin
            pos_in_field = pos_in_field + 4'd1;
        end else begin
            tag_pos = PH_FULL;
        end
    endtask

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item exp_it;
        t_item act_it;
        if (!i_rst_n) begin
            tag_r        = TAG_RESET;
            tag_pos      = '0;
            tag_ok       = 1'b0;
            in_sentence  = 1'b0;
            field_count  = '0;
            pos_in_field = '0;
            field_char_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                act_it = {m_axis_tlast, m_axis_tdata};
                results++;
                if (field_char_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, act_it);
                    fails++;
                end else begin
                    exp_it = field_char_q.pop_front();
                    compare_field("field_index", exp_it.field_index, act_it.field_index);
                    compare_field("char_pos", exp_it.char_pos, act_it.char_pos);
                    compare_field("char_value", exp_it.char_value, act_it.char_value);
                    compare_field("sentence_end", exp_it.sentence_end, act_it.sentence_end);
                end
            end
            if (s_axis_tvalid && s_axis_tready) split_char(s_axis_tdata);
            if (i_cfg_wr_en) tag_r = i_cfg_wr_data;
        end
        o_pending      <= field_char_q.size();
        o_fail_count   <= fails;
        o_result_count <= results;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the NMEA field splitter: stimulus, tag phases and verdict.
module tb;
    import nsfs_pkg::*;

    localparam int ItemTarget   = 650;
    localparam int NumPhases    = 6;
    localparam int SettleCycles = 4;
    localparam int CycleLimit   = 200000;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_cfg_wr_en   = 1'b0;
    logic [TagW-1:0] i_cfg_wr_data = '0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata  = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [15:0]     m_axis_tdata;
    logic            m_axis_tlast;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count   = 0;
    int burst_left    = 0;
    int beats_sent    = 0;
    int noise_beats   = 0;
    int sentence_cnt  = 0;
    int ready_hold    = 0;

    logic [TagW-1:0] phase_tags [NumPhases];

    nmea_sentence_field_splitter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    nmea_split_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CycleLimit) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_axis_tready <= 1'b0;
                    ready_hold    <= $urandom_range(1, 8);
                end
                3: begin
                    m_axis_tready <= 1'b1;
                    ready_hold    <= $urandom_range(20, 60);
                end
                default: begin
                    m_axis_tready <= 1'b1;
                    ready_hold    <= $urandom_range(1, 6);
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] field_char();
        logic [7:0] c;
        do c = $urandom_range(0, 255);
        while (c == CH_START || c == CH_CR || c == CH_COMMA || c == CH_STAR);
        return c;
    endfunction

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            send_byte(field_char());
            noise_beats++;
        end
    endtask

    task automatic send_sentence(input logic [TagW-1:0] tag);
        int         form;
        int         bad_pos;
        int         nfields;
        int         flen;
        logic [7:0] c;
        form    = $urandom_range(0, 9);
        bad_pos = $urandom_range(0, 4);
        sentence_cnt++;
        if (form == 2) begin
            send_byte(CH_START);
            for (int k = 0; k < bad_pos; k++) send_byte(tag[8 * (4 - k) +: 8]);
        end
        send_byte(CH_START);
        for (int k = 0; k < 5; k++) begin
            c = tag[8 * (4 - k) +: 8];
            if (form == 0 && k == bad_pos) c = c ^ (8'h01 << $urandom_range(0, 7));
            if (form == 1 && k == bad_pos) begin
                send_byte(CH_CR);
                return;
            end
            send_byte(c);
        end
        flen = $urandom_range(0, 2);
        for (int i = 0; i < flen; i++) send_byte(field_char());
        nfields = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 16) : $urandom_range(0, 5);
        for (int f = 0; f < nfields; f++) begin
            send_byte($urandom_range(0, 1) ? CH_COMMA : CH_STAR);
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
            for (int i = 0; i < flen; i++) send_byte(field_char());
        end
        if (form != 3) send_byte(CH_CR);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_tag(input logic [TagW-1:0] tag);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= tag;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int phase_end;
        phase_tags[0] = TAG_RESET;
        phase_tags[1] = '0;
        phase_tags[2] = '1;
        phase_tags[3] = {CH_COMMA, CH_STAR, CH_COMMA, CH_STAR, CH_COMMA};
        phase_tags[4] = {8'($urandom_range(0, 255)), 32'($urandom)};
        phase_tags[5] = TAG_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("$GPRMC,");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_STAR);
        send_byte(CH_CR);
        send_text("$GP");
        send_byte(CH_CR);
        send_text("$G$GPRMX,1");
        send_byte(CH_CR);

        for (int ph = 0; ph < NumPhases; ph++) begin
            if (ph != 0) write_tag(phase_tags[ph]);
            phase_end = (ph + 1) * ItemTarget / NumPhases;
            do begin
                if ($urandom_range(0, 3) == 0) send_noise();
                send_sentence(phase_tags[ph]);
            end while (beats_sent < phase_end);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d beats (%0d noise) in %0d sentences over %0d tag settings.",
                 beats_sent, noise_beats, sentence_cnt, NumPhases);
        $display("Checked %0d field beats, %0d failures.", result_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== nmea_sentence_field_splitter_core.f =====
rtl/nsfs_pkg.sv
rtl/nsfs_front.sv
rtl/nsfs_queue.sv
rtl/nsfs_back.sv
rtl/nmea_sentence_field_splitter_core.sv
tb/nmea_split_checker.sv
tb/tb.sv
